/* rtl/core/xtea_block_cipher_top_macros.svh */
// Assertion macros used by the checker file of the cipher block.
`ifndef XTEA_BLOCK_CIPHER_TOP_MACROS_SVH
`define XTEA_BLOCK_CIPHER_TOP_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define XTEA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Concurrent assertion that is checked in reset as well.
`define XTEA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/xtea_pkg.sv */
package xtea_pkg;

   // Word and key geometry.
   localparam int unsigned WORD_WIDTH      = 32;
   localparam int unsigned KEY_COUNT       = 4;
   localparam int unsigned KEY_INDEX_WIDTH = 2;

   // Round constant of the cipher.
   localparam logic [WORD_WIDTH-1:0] DELTA = 32'h9E37_79B9;

   // Shift amounts of the mixing function and of the second key select.
   localparam int unsigned MIX_LEFT     = 4;
   localparam int unsigned MIX_RIGHT    = 5;
   localparam int unsigned KEY_SEL_SHIFT = 11;

   // Operation requested for an item.
   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } op_type;

   // Key words as loaded through the register port.
   typedef logic [KEY_COUNT-1:0][WORD_WIDTH-1:0] key_array_type;

   // One block in flight with its operation.
   typedef struct packed {
      op_type                op;
      logic [WORD_WIDTH-1:0] first;
      logic [WORD_WIDTH-1:0] second;
   } block_type;

   // What one pipeline stage hands to the next.
   typedef struct packed {
      logic      valid;
      block_type block;
   } stage_type;

endpackage

/* rtl/core/xtea_stage.sv */
module xtea_stage #(
   parameter int unsigned ROUNDS = 32,
   parameter int unsigned STAGE  = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  xtea_pkg::key_array_type key,
   input  xtea_pkg::stage_type   stage_in,
   output xtea_pkg::stage_type   stage_out
);

   // Round index and half of this stage; all round sums are fixed here.
   localparam int unsigned ROUND_IDX = STAGE / 2;
   localparam int unsigned HALF      = STAGE % 2;
   localparam bit          ODD       = (HALF == 1);
   localparam logic [31:0] ENC_SUM   =
      32'(64'(xtea_pkg::DELTA) * 64'(ROUND_IDX + HALF));
   localparam logic [31:0] DEC_SUM   =
      32'(64'(xtea_pkg::DELTA) * 64'(ROUNDS - ROUND_IDX - HALF));
   localparam int unsigned KS = xtea_pkg::KEY_SEL_SHIFT;
   localparam logic [xtea_pkg::KEY_INDEX_WIDTH-1:0] ENC_SEL =
      ODD ? ENC_SUM[KS +: xtea_pkg::KEY_INDEX_WIDTH]
          : ENC_SUM[xtea_pkg::KEY_INDEX_WIDTH-1:0];
   localparam logic [xtea_pkg::KEY_INDEX_WIDTH-1:0] DEC_SEL =
      ODD ? DEC_SUM[xtea_pkg::KEY_INDEX_WIDTH-1:0]
          : DEC_SUM[KS +: xtea_pkg::KEY_INDEX_WIDTH];

   logic                                  decrypt;
   logic                                  upd_first;
   logic [31:0]                           src_word;
   logic [31:0]                           dst_word;
   logic [31:0]                           mix_word;
   logic [31:0]                           sum_word;
   logic [xtea_pkg::KEY_INDEX_WIDTH-1:0]  key_sel;
   logic [31:0]                           key_word;
   logic [31:0]                           f_word;
   logic [31:0]                           new_word;
   logic                                  valid_ff;
   logic                                  valid_in;
   xtea_pkg::block_type                   block_ff;
   xtea_pkg::block_type                   block_in;

   // Encryption updates the first word on even stages, decryption on odd ones.
   assign decrypt   = (stage_in.block.op == xtea_pkg::OP_DECRYPT);
   assign upd_first = (decrypt == ODD);
   assign src_word  = upd_first ? stage_in.block.second : stage_in.block.first;
   assign dst_word  = upd_first ? stage_in.block.first : stage_in.block.second;

   // Half round: mix the other word and combine it with sum plus key.
   always_comb begin
      mix_word = ((src_word << xtea_pkg::MIX_LEFT) ^ (src_word >> xtea_pkg::MIX_RIGHT))
                 + src_word;
      sum_word = decrypt ? DEC_SUM : ENC_SUM;
      key_sel  = decrypt ? DEC_SEL : ENC_SEL;
      key_word = sum_word + key[key_sel];
      f_word   = mix_word ^ key_word;
      new_word = decrypt ? (dst_word - f_word) : (dst_word + f_word);
   end

   // Next stage contents.
   always_comb begin
      valid_in = stage_in.valid;
      block_in = stage_in.block;
      if (upd_first) begin
         block_in.first = new_word;
      end else begin
         block_in.second = new_word;
      end
   end

   // Stage register, held while the pipeline is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         block_ff <= block_in;
      end
   end

   assign stage_out.valid = valid_ff;
   assign stage_out.block = block_ff;

endmodule

/* rtl/core/xtea_block_cipher_top.sv */
// XTEA block cipher, 64-bit blocks, 128-bit key. Each item carries the two
// 32-bit words of a block in req_tdata and the operation in req_tuser
// (0 encrypt, 1 decrypt); the result block comes back on rsp_tdata, one item
// per input item, in input order. The rounds are laid out as a pipeline of
// 2*ROUNDS register stages, one half round each, so a new block can be taken
// in every cycle while the output holding entry is empty. A single holding
// entry at the output lets the pipeline move once more when a result is
// refused; req_tready then stays low until that entry drains. The key
// words are written through the csr_ port (index 0 to 3) and are used by
// every stage directly, so they may only be changed while no item is in
// flight.
module xtea_block_cipher_top #(
   parameter int unsigned ROUNDS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // in_first [31:0], in_second [63:32]
   input  logic        req_tuser,   // operation [0]
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // out_first [31:0], out_second [63:32]
   // Key register writes.
   input  logic                                  csr_we,
   input  logic [xtea_pkg::KEY_INDEX_WIDTH-1:0]  csr_index,
   input  logic [xtea_pkg::WORD_WIDTH-1:0]       csr_wdata
);

   localparam int unsigned STAGES = 2 * ROUNDS;

   xtea_pkg::key_array_type key_ff;
   xtea_pkg::key_array_type key_in;
   xtea_pkg::stage_type     stage_link [STAGES+1];
   logic                    advance;
   logic                    skid_valid_ff;
   logic                    skid_valid_in;
   xtea_pkg::block_type     skid_ff;
   xtea_pkg::block_type     skid_in;
   xtea_pkg::block_type     rsp_block;

   // Key registers.
   always_comb begin
      key_in = key_ff;
      if (csr_we) begin
         key_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   // The pipeline moves whenever the output holding entry is free.
   assign advance    = !skid_valid_ff;
   assign req_tready = advance;

   // Feed of the first stage.
   assign stage_link[0].valid        = req_tvalid;
   assign stage_link[0].block.op     = xtea_pkg::op_type'(req_tuser);
   assign stage_link[0].block.first  = req_tdata[31:0];
   assign stage_link[0].block.second = req_tdata[63:32];

   // One half round per stage.
   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      xtea_stage #(
         .ROUNDS (ROUNDS),
         .STAGE  (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .key       (key_ff),
         .stage_in  (stage_link[i]),
         .stage_out (stage_link[i+1])
      );
   end

   // Holding entry: catches the last stage when the result side stalls.
   always_comb begin
      skid_valid_in = (skid_valid_ff || stage_link[STAGES].valid) && !rsp_tready;
      skid_in       = skid_valid_ff ? skid_ff : stage_link[STAGES].block;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      skid_ff <= skid_in;
   end

   // Result item: the holding entry comes first, it is always older.
   assign rsp_tvalid = skid_valid_ff || stage_link[STAGES].valid;
   assign rsp_block  = skid_valid_ff ? skid_ff : stage_link[STAGES].block;
   assign rsp_tdata  = {rsp_block.second, rsp_block.first};

endmodule

/* rtl/core/xtea_checker.sv */
`include "xtea_block_cipher_top_macros.svh"

module xtea_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // The input side stops only after a result was refused.
   property p_stall_start;
      $fell(req_tready) |-> $past(rsp_tvalid && !rsp_tready);
   endproperty

   // A refused result stays offered with the same payload.
   property p_rsp_hold;
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata);
   endproperty

   // Reset empties the pipeline and the holding entry.
   `XTEA_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result after reset")

   // The input side only stops while a result is waiting.
   `XTEA_ASSERT(a_stall_cause, clock, reset, !req_tready |-> rsp_tvalid, "stall without result")

   `XTEA_ASSERT(a_stall_start, clock, reset, p_stall_start, "stall without refusal")

   `XTEA_ASSERT(a_rsp_hold, clock, reset, p_rsp_hold, "result dropped")

endmodule

bind xtea_block_cipher_top xtea_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
